### sv/aarm_pkg.sv
package aarm_pkg;

  localparam int unsigned TrigIterDefault = 16;
  localparam int unsigned AtanEntries     = 24;
  localparam int unsigned AngW            = 33;
  localparam int unsigned XyW             = 32;
  localparam logic signed [XyW-1:0] CordicGainQ30 = 32'sd652032874;
  localparam logic signed [17:0] OneQ16 = 18'sd65536;
  localparam logic signed [17:0] OutMax = 18'sd131071;
  localparam logic signed [17:0] OutMin = -18'sd131071 - 18'sd1;

  typedef struct packed {
    logic signed [XyW-1:0] x;
    logic signed [XyW-1:0] y;
    logic signed [AngW-1:0] z;
    logic                   flip;
    logic signed [15:0]     nx;
    logic signed [15:0]     ny;
    logic signed [15:0]     nz;
  } cordic_stage_t;

  // atan(2^-i) as a binary angle, 2^32 for a full turn.
  function automatic logic signed [AngW-1:0] atan_entry(input int unsigned idx);
    logic signed [AngW-1:0] r;
    begin
      r = '0;
      unique case (idx)
        0: r = 33'sd536870912;
        1: r = 33'sd316933406;
        2: r = 33'sd167458907;
        3: r = 33'sd85004756;
        4: r = 33'sd42667331;
        5: r = 33'sd21354465;
        6: r = 33'sd10679838;
        7: r = 33'sd5340245;
        8: r = 33'sd2670163;
        9: r = 33'sd1335087;
        10: r = 33'sd667544;
        11: r = 33'sd333772;
        12: r = 33'sd166886;
        13: r = 33'sd83443;
        14: r = 33'sd41722;
        15: r = 33'sd20861;
        16: r = 33'sd10430;
        17: r = 33'sd5215;
        18: r = 33'sd2608;
        19: r = 33'sd1304;
        20: r = 33'sd652;
        21: r = 33'sd326;
        22: r = 33'sd163;
        23: r = 33'sd81;
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

### sv/aarm_cordic_cell.sv
module aarm_cordic_cell
  import aarm_pkg::*;
#(
  parameter int unsigned STEP = 0
) (
  input  logic          clk,
  input  logic          en,
  input  cordic_stage_t d_in,
  output cordic_stage_t d_out
);

  cordic_stage_t q_r;
  cordic_stage_t q_nxt;
  logic signed [XyW-1:0] dx;
  logic signed [XyW-1:0] dy;

  // Arithmetic shift floors, matching the rounding of the stage.
  assign dx = d_in.y >>> STEP;
  assign dy = d_in.x >>> STEP;

  always_comb begin
    q_nxt = d_in;
    if (!d_in.z[AngW-1]) begin
      q_nxt.x = d_in.x - dx;
      q_nxt.y = d_in.y + dy;
      q_nxt.z = d_in.z - atan_entry(STEP);
    end else begin
      q_nxt.x = d_in.x + dx;
      q_nxt.y = d_in.y - dy;
      q_nxt.z = d_in.z + atan_entry(STEP);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      q_r <= q_nxt;
    end
  end

  assign d_out = q_r;

endmodule

### sv/aarm_matrix.sv
module aarm_matrix
  import aarm_pkg::*;
(
  input  logic               clk,
  input  logic               en,
  input  cordic_stage_t      d_in,
  output logic [9*18-1:0]    m_out
);

  // Stage A: round trig results to Q16, take 1-c.
  logic signed [XyW-1:0] xf;
  logic signed [XyW-1:0] yf;
  logic signed [XyW:0]   xr;
  logic signed [XyW:0]   yr;
  logic signed [17:0] c_r, s_r;
  logic signed [18:0] omc_r;
  logic signed [15:0] ax_r, ay_r, az_r;
  logic signed [17:0] c2_r;
  logic signed [18:0] omc2_r;
  logic signed [31:0] p_r [9];
  logic signed [33:0] sv_r [3];
  logic signed [63:0] t_r [9];
  logic signed [63:0] u_r [9];
  logic signed [17:0] o_r [9];

  assign xf = d_in.flip ? -d_in.x : d_in.x;
  assign yf = d_in.flip ? -d_in.y : d_in.y;
  assign xr = {xf[XyW-1], xf} + 33'sd8192;
  assign yr = {yf[XyW-1], yf} + 33'sd8192;

  // 1-c reaches 2.0 at half a turn, so it needs one bit more than c.
  always_ff @(posedge clk) begin
    if (en) begin
      c_r   <= 18'(xr >>> 14);
      s_r   <= 18'(yr >>> 14);
      omc_r <= 19'(OneQ16) - 19'(xr >>> 14);
      ax_r <= d_in.nx; ay_r <= d_in.ny; az_r <= d_in.nz;
    end
  end

  // Stage B: axis products and axis times sine.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0] <= ax_r * ax_r; p_r[1] <= ax_r * ay_r; p_r[2] <= ax_r * az_r;
      p_r[3] <= ay_r * ax_r; p_r[4] <= ay_r * ay_r; p_r[5] <= ay_r * az_r;
      p_r[6] <= az_r * ax_r; p_r[7] <= az_r * ay_r; p_r[8] <= az_r * az_r;
      sv_r[0] <= 34'(ax_r) * 34'(s_r);
      sv_r[1] <= 34'(ay_r) * 34'(s_r);
      sv_r[2] <= 34'(az_r) * 34'(s_r);
      c2_r <= c_r; omc2_r <= omc_r;
    end
  end

  // Stage C: scale by 1-c; cross terms and cosine shifted into Q44.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        t_r[k] <= 64'(p_r[k]) * 64'(omc2_r);
      end
      u_r[0] <= 64'(c2_r) <<< 28;
      u_r[4] <= 64'(c2_r) <<< 28;
      u_r[8] <= 64'(c2_r) <<< 28;
      u_r[1] <= -(64'(sv_r[2]) <<< 14);
      u_r[2] <=  (64'(sv_r[1]) <<< 14);
      u_r[3] <=  (64'(sv_r[2]) <<< 14);
      u_r[5] <= -(64'(sv_r[0]) <<< 14);
      u_r[6] <= -(64'(sv_r[1]) <<< 14);
      u_r[7] <=  (64'(sv_r[0]) <<< 14);
    end
  end

  // Stage D: sum, round to Q14 and saturate.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 9; k++) begin
        logic signed [63:0] sm;
        sm = (t_r[k] + u_r[k] + 64'sd536870912) >>> 30;
        if (sm > 64'(OutMax)) begin
          o_r[k] <= OutMax;
        end else if (sm < 64'(OutMin)) begin
          o_r[k] <= OutMin;
        end else begin
          o_r[k] <= sm[17:0];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 9; k++) begin
      m_out[k*18 +: 18] = o_r[k];
    end
  end

endmodule

### sv/axis_angle_rotation_matrix_unit.sv
// Channel | Ports            | Beat contents
// input   | in_t*            | axis_x, axis_y, axis_z, turn_angle (64 bits)
// output  | out_t*           | m00..m22, 18 bits each, row major (168 bits)
//
// One beat is taken every clock cycle unless the output stalls. Steps is
// TRIG_ITERATIONS capped at 24. The pipeline has one input stage, one CORDIC
// cell per iteration and four matrix stages, the last of which is the output
// register. The whole pipeline advances together and holds while a finished
// beat waits at the output, so in_tready follows the output slot.
// Reset clears only the valid flags of the pipeline.
module axis_angle_rotation_matrix_unit
  import aarm_pkg::*;
#(
  parameter int unsigned TRIG_ITERATIONS = TrigIterDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // axis_x [15:0], axis_y [31:16], axis_z [47:32], turn_angle [63:48]
  input  logic [63:0]  in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // m00 [17:0], m01, m02, m10, m11, m12, m20, m21, m22 [161:144], zero pad
  output logic [167:0] out_tdata
);

  // Steps beyond the arctangent table are not run.
  localparam int unsigned Steps =
    (TRIG_ITERATIONS < AtanEntries) ? TRIG_ITERATIONS : AtanEntries;
  localparam int unsigned Depth = Steps + 5;

  logic [Depth-1:0] vld_r;
  logic             adv;
  cordic_stage_t    pre_r;
  cordic_stage_t    pre_nxt;
  cordic_stage_t    chain [Steps+1];
  logic [31:0]      a32;
  logic [9*18-1:0]  m_w;

  // The pipeline moves when its last slot is empty or being drained.
  assign adv       = !vld_r[Depth-1] || out_tready;
  assign in_tready = adv;
  assign out_tvalid = vld_r[Depth-1];
  assign out_tdata  = {6'd0, m_w};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[Depth-2:0], in_tvalid};
    end
  end

  // Fold the left half plane onto the right, flipping the results later.
  always_comb begin
    logic flip;
    logic [31:0] zu;
    a32 = {in_tdata[63:48], 16'd0};
    flip = (a32 >= 32'h4000_0000) && (a32 < 32'hC000_0000);
    zu = flip ? (a32 ^ 32'h8000_0000) : a32;
    pre_nxt.x = CordicGainQ30;
    pre_nxt.y = '0;
    pre_nxt.z = {zu[31], zu};
    pre_nxt.flip = flip;
    pre_nxt.nx = in_tdata[15:0];
    pre_nxt.ny = in_tdata[31:16];
    pre_nxt.nz = in_tdata[47:32];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pre_r <= pre_nxt;
    end
  end

  assign chain[0] = pre_r;

  for (genvar g = 0; g < Steps; g++) begin : g_cell
    aarm_cordic_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .en   (adv),
      .d_in (chain[g]),
      .d_out(chain[g+1])
    );
  end

  aarm_matrix u_matrix (
    .clk  (clk),
    .en   (adv),
    .d_in (chain[Steps]),
    .m_out(m_w)
  );

`ifndef NO_ASSERTIONS
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input blocked with empty output");
  a_pad: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[167:162] == 6'd0)
    else $error("padding bits set");
`endif

endmodule
